// ----- rtl/core/first_fit_block_allocator_defines.svh -----
// Assertion macros shared by the checkers of the first-fit block allocator.
// Depends on nothing; included by the checker file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ffba_pkg.sv -----
// Shared types and constants of the first-fit block allocator.
// Depends on nothing; imported by every module of the block.
package ffba_pkg;

   localparam int CMD_W       = 1;
   localparam int SIZE_W      = 13;
   localparam int OFFS_W      = 12;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NOSPACE  = 2'd1,
      ST_NOTBLOCK = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Packed with status in the lowest bits.
   typedef struct packed {
      logic [OFFS_W-1:0] given_offset;
      status_type        status;
   } rsp_type;

endpackage

// ----- rtl/core/ffba_desc_mem.sv -----
// Block descriptor memory: one write port, one read port, registered read.
// Depends on ffba_pkg.
module ffba_desc_mem
   import ffba_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int DW    = 26,
   localparam int IW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ffba_ctrl.sv -----
// Request sequencer: walks the descriptor memory, decides each request,
// writes descriptors back and keeps the block count and frontier.
// Depends on ffba_pkg.
module ffba_ctrl
   import ffba_pkg::*;
#(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_BLOCKS   = 64,
   localparam int IW   = $clog2(MAX_BLOCKS),
   localparam int SW   = $clog2(ARENA_BYTES),
   localparam int DW   = 1 + SIZE_W + SW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [SIZE_W-1:0] req_size,
   input  logic [OFFS_W-1:0] req_offset,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_type           res_data,
   output logic              rd_en,
   output logic [IW-1:0]     rd_addr,
   input  logic [DW-1:0]     rd_data,
   output logic              wr_en,
   output logic [IW-1:0]     wr_addr,
   output logic [DW-1:0]     wr_data
);

   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int AW   = $clog2(ARENA_BYTES + 1);
   localparam int SUMW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
   localparam int CMPW = (SW > OFFS_W) ? SW : OFFS_W;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [OFFS_W-1:0]  offs_ff, offs_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               chk_ff, chk_in;
   logic [AW-1:0]      frontier_ff, frontier_in;
   status_type         res_status_ff, res_status_in;
   logic [OFFS_W-1:0]  res_offs_ff, res_offs_in;

   logic               accept;
   logic               zero_size;
   logic               rd_used;
   logic [SIZE_W-1:0]  rd_cap;
   logic [SW-1:0]      rd_start;
   logic               hit;
   logic               issue;
   logic               exhausted;
   logic [SUMW-1:0]    start_sum;
   logic [SUMW-1:0]    end_sum;
   logic               room;
   logic [SW-1:0]      new_start;
   logic               carve;

   assign accept    = req_valid && req_ready;
   assign zero_size = (req_cmd == CMD_ALLOC) && (req_size == '0);

   assign rd_used  = rd_data[DW-1];
   assign rd_cap   = rd_data[SW +: SIZE_W];
   assign rd_start = rd_data[SW-1:0];

   // rd_data holds the entry issued in the previous scan cycle.
   assign hit = chk_ff && ((cmd_ff == CMD_ALLOC) ? (!rd_used && (rd_cap >= size_ff))
                                                 : (CMPW'(rd_start) == CMPW'(offs_ff)));
   assign issue     = scan_ff < count_ff;
   assign exhausted = !chk_ff && !issue;

   assign start_sum = SUMW'(frontier_ff) + SUMW'(HEADER_BYTES);
   assign end_sum   = start_sum + SUMW'(size_ff);
   assign room      = (count_ff < CW'(MAX_BLOCKS)) && (end_sum <= SUMW'(ARENA_BYTES));
   assign new_start = SW'(start_sum);
   assign carve     = (state_ff == S_SCAN) && !hit && exhausted &&
                      (cmd_ff == CMD_ALLOC) && room;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = zero_size ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit || exhausted) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      res_valid = (state_ff == S_FINISH);
      res_data.status       = res_status_ff;
      res_data.given_offset = res_offs_ff;
      rd_en   = (state_ff == S_SCAN) && issue;
      rd_addr = scan_ff[IW-1:0];
      wr_en   = ((state_ff == S_SCAN) && hit) || carve;
      if (hit) begin
         wr_addr = IW'(scan_ff - CW'(1));
         wr_data = {(cmd_ff == CMD_ALLOC), rd_cap, rd_start};
      end else begin
         wr_addr = count_ff[IW-1:0];
         wr_data = {1'b1, size_ff, new_start};
      end
   end

   // Datapath next values
   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      offs_in       = offs_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      chk_in        = chk_ff;
      frontier_in   = frontier_ff;
      res_status_in = res_status_ff;
      res_offs_in   = res_offs_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd;
               size_in       = req_size;
               offs_in       = req_offset;
               scan_in       = '0;
               chk_in        = 1'b0;
               res_status_in = ST_NOSPACE;
               res_offs_in   = '0;
            end
         end
         S_SCAN: begin
            chk_in = 1'b0;
            if (hit) begin
               res_status_in = ST_DONE;
               res_offs_in   = (cmd_ff == CMD_ALLOC) ? OFFS_W'(rd_start) : '0;
            end else if (exhausted) begin
               res_offs_in = '0;
               if (cmd_ff == CMD_FREE) begin
                  res_status_in = ST_NOTBLOCK;
               end else if (room) begin
                  res_status_in = ST_DONE;
                  res_offs_in   = OFFS_W'(new_start);
                  frontier_in   = AW'(end_sum);
                  count_in      = count_ff + CW'(1);
               end else begin
                  res_status_in = ST_NOSPACE;
               end
            end else begin
               chk_in = issue;
               if (issue) begin
                  scan_in = scan_ff + CW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_ff     <= '0;
         count_ff    <= '0;
         chk_ff      <= 1'b0;
         frontier_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         count_ff    <= count_in;
         chk_ff      <= chk_in;
         frontier_ff <= frontier_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      offs_ff       <= offs_in;
      res_status_ff <= res_status_in;
      res_offs_ff   <= res_offs_in;
   end

endmodule

// ----- rtl/core/ffba_rsp_slot.sv -----
// Output register of the response channel: holds one result until taken.
// Depends on ffba_pkg.
module ffba_rsp_slot
   import ffba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/first_fit_block_allocator.sv -----
// First-fit block allocator over a fixed arena: top level.
// Depends on ffba_pkg, ffba_ctrl, ffba_desc_mem and ffba_rsp_slot.
//
// The block serves one request at a time. An allocate walks the carved
// blocks in order, one descriptor per cycle through the single read port of
// the descriptor memory, and reuses the first unused block that is large
// enough; otherwise it carves a new block at the frontier. A free walks the
// same descriptors looking for a matching data offset. A zero-size allocate
// skips the walk. Results land in an output register, so the next request
// is taken while a result still waits on rsp_tready. Descriptors need no
// clearing after reset: only entries below the block count are ever read,
// and each is written when carved.
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_BLOCKS   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [12:0] req_size, [24:13] data_offset
   input  logic [CMD_W-1:0]       req_tuser,   // [0] cmd (0 allocate, 1 free)
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [1:0] status, [13:2] given_offset
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int SW = $clog2(ARENA_BYTES);
   localparam int DW = 1 + SIZE_W + SW;

   // descriptor memory port
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [DW-1:0] rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] wr_data;

   // sequencer to output register
   logic    res_valid;
   logic    res_ready;
   rsp_type res_data;
   rsp_type rsp_data;

   // Unpack the request fields.
   logic [SIZE_W-1:0] req_size;
   logic [OFFS_W-1:0] data_offset;

   assign req_size    = req_tdata[SIZE_W-1:0];
   assign data_offset = req_tdata[SIZE_W +: OFFS_W];

   // Sequence requests; hold each one until its result is registered.
   ffba_ctrl #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_size   (req_size),
      .req_offset (data_offset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_data   (res_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // Store {used, capacity, data start} per block. A write-back always ends
   // a walk, so no read of the same entry overlaps it.
   ffba_desc_mem #(
      .DEPTH (MAX_BLOCKS),
      .DW    (DW)
   ) u_desc_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Decouple the response side from the walk.
   ffba_rsp_slot u_rsp_slot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // Pad the response with zeros to whole bytes.
   assign rsp_tdata = RSP_TDATA_W'(rsp_data);

endmodule

// ----- rtl/core/ffba_checker.sv -----
// Port-level checker for the first-fit block allocator, bound to the top.
// Depends on ffba_pkg and first_fit_block_allocator_defines.svh.
`include "first_fit_block_allocator_defines.svh"

module ffba_checker
   import ffba_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response holds.
   `FFBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // Only one request is in work at a time.
   `FFBA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while another is in work")

   // Status is one of the three defined codes, padding stays zero.
   `FFBA_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[15:14] == 2'b00), "bad status code or padding")

   // An offset is given only with a done status.
   `FFBA_ASSERT_NOW(a_offset_zero, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != 2'd0), rsp_tdata[13:2] == 12'd0, "offset given on a failed request")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/first_fit_block_allocator_test.sv -----
// Testbench for the first-fit block allocator: directed and random allocate/free
// requests, each response checked against a behavioral arena model or typed row.
// Depends on ffba_pkg and first_fit_block_allocator.
module first_fit_block_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ffba_pkg::*;

   localparam int ARENA_BYTES  = 4096;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 64;
   localparam int RANDOM_REQS  = 700;
   localparam int DRAIN_EVERY  = 175;
   // no handshake on either side for this long means the block is hung
   localparam int IDLE_LIMIT   = 2000;
   // a full descriptor walk plus the result register, with margin
   localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;
   localparam int PAD_W = REQ_TDATA_W - SIZE_W - OFFS_W;

   // One directed request; typed rows carry the response read off by hand,
   // the others take the arena model's answer.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SIZE_W-1:0] size;
      logic [OFFS_W-1:0] offs;
      bit                typed;
      status_type        st;
      logic [OFFS_W-1:0] given;
   } dir_row_type;

   localparam int N_DIRECTED = 21;
   localparam dir_row_type DIRECTED_ROWS[N_DIRECTED] = '{
      // zero size on an empty arena, frees with nothing carved
      '{CMD_ALLOC, 13'd0,    12'hFFF, 1'b1, ST_NOSPACE,  12'd0},
      '{CMD_FREE,  13'h1FFF, 12'd0,   1'b1, ST_NOTBLOCK, 12'd0},
      '{CMD_FREE,  13'd0,    12'hFFF, 1'b1, ST_NOTBLOCK, 12'd0},
      // first carve lands right after one header
      '{CMD_ALLOC, 13'd1,    12'd0,   1'b1, ST_DONE,     12'd16},
      // requests past the arena end: field maximum and one byte over the room
      '{CMD_ALLOC, 13'd4096, 12'd0,   1'b1, ST_NOSPACE,  12'd0},
      '{CMD_ALLOC, 13'h1FFF, 12'hABC, 1'b1, ST_NOSPACE,  12'd0},
      '{CMD_ALLOC, 13'd4064, 12'd0,   1'b1, ST_NOSPACE,  12'd0},
      '{CMD_ALLOC, 13'd2,    12'd0,   1'b0, ST_DONE,     12'd0},
      // free, then free the same block again
      '{CMD_FREE,  13'h0AA,  12'd16,  1'b1, ST_DONE,     12'd0},
      '{CMD_FREE,  13'h155,  12'd16,  1'b1, ST_DONE,     12'd0},
      // too big for the freed block: carve; then one that fits: reuse
      '{CMD_ALLOC, 13'd2,    12'd0,   1'b0, ST_DONE,     12'd0},
      '{CMD_ALLOC, 13'd1,    12'd0,   1'b0, ST_DONE,     12'd0},
      // one byte past a data offset is not a block
      '{CMD_FREE,  13'd0,    12'd17,  1'b1, ST_NOTBLOCK, 12'd0},
      '{CMD_FREE,  13'd0,    12'd33,  1'b0, ST_DONE,     12'd0},
      '{CMD_FREE,  13'd0,    12'd51,  1'b0, ST_DONE,     12'd0},
      '{CMD_ALLOC, 13'd2,    12'd0,   1'b0, ST_DONE,     12'd0},
      '{CMD_ALLOC, 13'd3,    12'd0,   1'b0, ST_DONE,     12'd0},
      // zero size while a free block exists
      '{CMD_ALLOC, 13'd0,    12'd0,   1'b1, ST_NOSPACE,  12'd0},
      '{CMD_ALLOC, 13'd4009, 12'd0,   1'b0, ST_DONE,     12'd0},
      '{CMD_FREE,  13'd0,    12'd69,  1'b0, ST_DONE,     12'd0},
      '{CMD_ALLOC, 13'd3,    12'd0,   1'b0, ST_DONE,     12'd0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // arena model state
   bit     blk_in_use[MAX_BLOCKS];
   int     blk_cap[MAX_BLOCKS];
   int     blk_start[MAX_BLOCKS];
   int     blk_total;
   int     frontier_q;
   int     peak_blocks;

   rsp_type awaited_rsp[$];
   int      fault_count;
   int      n_alloc, n_free, n_done, n_nospace, n_notblock;
   int      stalled_cycles;
   int      rx_cycle = 0;
   int      rx_mode  = 0;

   first_fit_block_allocator #(
      .ARENA_BYTES (ARENA_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Apply one request to the arena model and return the response it owes.
   function automatic rsp_type arena_apply(input logic [CMD_W-1:0] cmd,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [OFFS_W-1:0] offs);
      rsp_type r;
      bit      hit;
      r.given_offset = '0;
      hit = 1'b0;
      if (cmd == CMD_ALLOC) begin
         r.status = ST_NOSPACE;
         if (size != 0) begin
            // first fit among carved blocks; a reused block keeps its capacity
            for (int i = 0; i < blk_total && !hit; i++) begin
               if (!blk_in_use[i] && blk_cap[i] >= int'(size)) begin
                  blk_in_use[i]  = 1'b1;
                  r.status       = ST_DONE;
                  r.given_offset = blk_start[i][OFFS_W-1:0];
                  hit            = 1'b1;
               end
            end
            // carve at the frontier if header plus data still fit
            if (!hit && blk_total < MAX_BLOCKS &&
                frontier_q + HEADER_BYTES + int'(size) <= ARENA_BYTES) begin
               blk_in_use[blk_total] = 1'b1;
               blk_cap[blk_total]    = int'(size);
               blk_start[blk_total]  = frontier_q + HEADER_BYTES;
               r.status              = ST_DONE;
               r.given_offset        = blk_start[blk_total][OFFS_W-1:0];
               frontier_q            = frontier_q + HEADER_BYTES + int'(size);
               blk_total++;
               if (blk_total > peak_blocks)
                  peak_blocks = blk_total;
            end
         end
      end else begin
         r.status = ST_NOTBLOCK;
         for (int i = 0; i < blk_total && !hit; i++) begin
            if (blk_start[i] == int'(offs)) begin
               blk_in_use[i] = 1'b0;
               r.status      = ST_DONE;
               hit           = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Present one request at the falling edge and hold it until accepted.
   // Valid stays high afterward; the caller either sends again or drops it.
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [SIZE_W-1:0] size,
                               input logic [OFFS_W-1:0] offs,
                               input bit typed,
                               input rsp_type typed_rsp);
      rsp_type model_rsp;
      rsp_type owed;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{PAD_W{1'b0}}, offs, size};
      do
         @(posedge clock);
      while (!req_tready);
      model_rsp = arena_apply(cmd, size, offs);
      owed = typed ? typed_rsp : model_rsp;
      awaited_rsp.push_back(owed);
      if (cmd == CMD_ALLOC)
         n_alloc++;
      else
         n_free++;
      case (owed.status)
         ST_DONE:     n_done++;
         ST_NOSPACE:  n_nospace++;
         default:     n_notblock++;
      endcase
   endtask

   // Drop valid and idle the sender for a number of cycles.
   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic note_fault(input string what, input bit has_want,
                             input rsp_type want, input rsp_type got);
      fault_count++;
      if (fault_count <= 10) begin
         if (has_want)
            $display("%0t: %s: expected status %0d offset %0d, got status %0d offset %0d",
                     $realtime, what, want.status, want.given_offset,
                     got.status, got.given_offset);
         else
            $display("%0t: %s: got status %0d offset %0d",
                     $realtime, what, got.status, got.given_offset);
      end
   endtask

   // Receiver: switch at random between always ready, random stalls and a
   // periodic pattern that holds ready low for three quarters of its period.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 256 == 0)
         rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ((rx_cycle % 32) >= 24);
      endcase
   end

   // Compare each accepted response with the oldest one owed.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[STATUS_W+OFFS_W-1:0]);
         if (awaited_rsp.size() == 0) begin
            note_fault("response with nothing outstanding", 1'b0, got, got);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status || got.given_offset !== want.given_offset)
               note_fault("response mismatch", 1'b1, want, got);
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d responses owed",
                     IDLE_LIMIT, awaited_rsp.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int      sent;
      int      burst;
      int      gap;
      int      pick;
      int      idx;
      int      k;
      int      alloc_pct;
      logic [CMD_W-1:0]  cmd;
      logic [SIZE_W-1:0] size;
      logic [OFFS_W-1:0] offs;
      rsp_type           typed_rsp;

      blk_total   = 0;
      frontier_q  = 0;
      peak_blocks = 0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         blk_in_use[i] = 1'b0;
         blk_cap[i]    = 0;
         blk_start[i]  = 0;
      end

      // hold reset, then release it at a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed part: short random gaps, zero meaning back to back
      for (int r = 0; r < N_DIRECTED; r++) begin
         typed_rsp.status       = DIRECTED_ROWS[r].st;
         typed_rsp.given_offset = DIRECTED_ROWS[r].given;
         send_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].size,
                      DIRECTED_ROWS[r].offs, DIRECTED_ROWS[r].typed, typed_rsp);
         gap = $urandom_range(0, 3);
         if (gap != 0)
            hold_off(gap);
      end
      drain_responses();

      // random part: bursts of requests with random gaps; allocate-heavy
      // early so the arena fills toward its block limit or its end
      typed_rsp = rsp_type'('0);
      sent = 0;
      while (sent < RANDOM_REQS) begin
         burst = $urandom_range(1, 12);
         for (k = 0; k < burst && sent < RANDOM_REQS; k++) begin
            alloc_pct = (sent < RANDOM_REQS / 2) ? 70 : 45;
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
               cmd  = CMD_ALLOC;
               offs = OFFS_W'($urandom_range(0, 4095));
               pick = $urandom_range(0, 99);
               if (pick < 5)
                  size = '0;
               else if (pick < 72)
                  size = SIZE_W'($urandom_range(1, 40));
               else if (pick < 87)
                  size = SIZE_W'($urandom_range(41, 200));
               else
                  size = SIZE_W'($urandom_range(4081, 8191));
            end else begin
               cmd  = CMD_FREE;
               size = SIZE_W'($urandom_range(0, 8191));
               pick = $urandom_range(0, 99);
               if (blk_total > 0 && pick < 75) begin
                  // free a carved block, now and then one byte off its start
                  idx  = $urandom_range(0, blk_total - 1);
                  offs = blk_start[idx][OFFS_W-1:0];
                  if (pick < 8)
                     offs = offs + OFFS_W'(1);
                  else if (pick < 12)
                     offs = offs - OFFS_W'(1);
               end else begin
                  offs = OFFS_W'($urandom_range(0, 4095));
               end
            end
            send_request(cmd, size, offs, 1'b0, typed_rsp);
            sent++;
            if (sent % DRAIN_EVERY == 0)
               drain_responses();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0)
            hold_off(gap);
      end
      hold_off(1);

      // wait out every owed response, then let the block settle
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      fault_count += awaited_rsp.size();

      $display("Sent %0d requests (%0d allocate, %0d free): %0d done, %0d no space, %0d not a block",
               n_alloc + n_free, n_alloc, n_free, n_done, n_nospace, n_notblock);
      $display("Arena reached %0d of %0d blocks, frontier at byte %0d of %0d; %0d faults",
               peak_blocks, MAX_BLOCKS, frontier_q, ARENA_BYTES, fault_count);
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- first_fit_block_allocator.f -----
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_desc_mem.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_rsp_slot.sv
rtl/core/first_fit_block_allocator.sv
rtl/core/ffba_checker.sv
tb/first_fit_block_allocator_test.sv
